// ----- rtl/aligned_stack_allocator_macros.svh -----
// Assertion macros for the aligned stack allocator.
// Included by every RTL file that carries concurrent assertions.
`ifndef ALIGNED_STACK_ALLOCATOR_MACROS_SVH
`define ALIGNED_STACK_ALLOCATOR_MACROS_SVH
`ifndef SYNTHESIS
`define ASA_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ASA_ASSERT_NEXT(lbl, clk, rst, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);
`else
`define ASA_ASSERT(lbl, clk, rst, prop, msg)
`define ASA_ASSERT_NEXT(lbl, clk, rst, pre, post, msg)
`endif
`endif

// ----- rtl/asa_pkg.sv -----
// Types, codes and constants of the aligned stack allocator.
// No dependencies; used by the interfaces, the RAM users and the top level.
`default_nettype none
package asa_pkg;

  localparam int OFF_W         = 13;
  localparam int ADDR_W        = 32;
  localparam int ALIGN_W       = 8;
  localparam int HDR_W         = 8;
  localparam int MEM_BYTES_DEF = 4096;
  localparam int MAX_ALIGN     = 128;
  localparam int HEADER_BYTES  = 1;

  typedef enum logic [1:0] {
    MODE_ALLOC = 2'd0,
    MODE_FREE  = 2'd1,
    MODE_CLEAR = 2'd2,
    MODE_NOP   = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_NO_SPACE  = 2'd1,
    STATUS_BAD_ALIGN = 2'd2,
    STATUS_BAD_FREE  = 2'd3
  } status_t;

  typedef enum logic [0:0] {
    CFG_BASE_ADDRESS = 1'b0,
    CFG_TOTAL_SIZE   = 1'b1
  } cfg_index_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CUR,
    S_PAD,
    S_FIT,
    S_CHK,
    S_ADDR,
    S_REL,
    S_HDR,
    S_DONE
  } state_t;

  typedef struct packed {
    mode_t              mode;
    logic [OFF_W-1:0]   request_size;
    logic [ALIGN_W-1:0] alignment;
    logic [ADDR_W-1:0]  free_address;
  } req_t;

  typedef struct packed {
    logic [ADDR_W-1:0] result_address;
    status_t           status;
    logic [OFF_W-1:0]  used_bytes;
    logic [OFF_W-1:0]  peak_bytes;
  } rsp_t;

  typedef struct packed {
    cfg_index_t        index;
    logic [ADDR_W-1:0] wdata;
  } cfg_t;

endpackage
`default_nettype wire

// ----- rtl/asa_ifs.sv -----
// Valid/ready channel interfaces of the aligned stack allocator.
// Depends on asa_pkg for the word types.
`default_nettype none
interface asa_req_if;
  logic          valid;
  logic          ready;
  asa_pkg::req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface asa_rsp_if;
  logic          valid;
  logic          ready;
  asa_pkg::rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface asa_cfg_if;
  logic          valid;
  logic          ready;
  asa_pkg::cfg_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- rtl/asa_ram.sv -----
// Generic simple dual-port RAM, one write port and one registered read port.
// No dependencies.
`default_nettype none
module asa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

// ----- rtl/aligned_stack_allocator.sv -----
// Aligned stack allocator: top level, sequencer around one shared 32-bit adder.
// Throughput: one word at a time; the next is taken once the sequencer is back in idle,
// and a result that is not taken holds the sequencer in its last state.
// Reset (rst, synchronous): offset and peak zero, base 0, total size 4096, output empty.
`default_nettype none
`include "aligned_stack_allocator_macros.svh"
module aligned_stack_allocator #(
  parameter int MEM_BYTES = asa_pkg::MEM_BYTES_DEF
) (
  input wire logic  clk,
  input wire logic  rst,
  asa_cfg_if.sink   cfg,
  asa_req_if.sink   req,
  asa_rsp_if.source rsp
);

  localparam int AW = $clog2(MEM_BYTES);
  localparam int IW = (AW > asa_pkg::OFF_W) ? AW : asa_pkg::OFF_W;

  asa_pkg::state_t         state, state_next;
  logic [31:0]             base_address;
  logic [12:0]             total_size;
  logic [12:0]             top;
  logic [12:0]             peak;
  asa_pkg::req_t           cmd;
  logic [31:0]             cur_addr;
  logic [7:0]              pad;
  logic [14:0]             acc;
  logic [12:0]             rel;
  logic [31:0]             res_addr;
  asa_pkg::status_t        res_status;
  logic                    out_valid;
  asa_pkg::rsp_t           out_word;
  logic                    out_load;
  logic [31:0]             add_a;
  logic [31:0]             add_b;
  logic                    add_cin;
  logic [31:0]             add_sum;
  logic                    bad_align;
  logic [12:0]             limit;
  logic                    no_space;
  logic                    rel_bad;
  logic                    hdr_we;
  logic [12:0]             hdr_wr_off;
  logic [12:0]             hdr_rd_off;
  logic [IW-1:0]           wr_wide;
  logic [IW-1:0]           rd_wide;
  logic [7:0]              hdr_rd_data;

  // configuration
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_address <= '0;
      total_size   <= 13'd4096;
    end else if (cfg.valid) begin
      case (cfg.data.index)
        asa_pkg::CFG_BASE_ADDRESS: base_address <= cfg.data.wdata;
        asa_pkg::CFG_TOTAL_SIZE:   total_size   <= cfg.data.wdata[12:0];
        default: ;
      endcase
    end
  end

  assign limit = (32'(total_size) > 32'(MEM_BYTES)) ? 13'(MEM_BYTES) : total_size;

  assign bad_align = (req.data.alignment == 8'd0) ||
                     ((req.data.alignment & (req.data.alignment - 8'd1)) != 8'd0) ||
                     (req.data.alignment > 8'(asa_pkg::MAX_ALIGN));

  // shared adder
  always_comb begin
    add_a   = '0;
    add_b   = '0;
    add_cin = 1'b0;
    case (state)
      asa_pkg::S_CUR: begin
        add_a = base_address;
        add_b = 32'(top);
      end
      asa_pkg::S_PAD: begin
        add_a = 32'(pad);
        add_b = 32'(cmd.alignment);
      end
      asa_pkg::S_FIT: begin
        add_a = 32'(top);
        add_b = 32'(pad);
      end
      asa_pkg::S_CHK: begin
        add_a = 32'(acc);
        add_b = 32'(cmd.request_size);
      end
      asa_pkg::S_ADDR: begin
        add_a = cur_addr;
        add_b = 32'(pad);
      end
      asa_pkg::S_REL: begin
        add_a   = cmd.free_address;
        add_b   = ~base_address;
        add_cin = 1'b1;
      end
      asa_pkg::S_HDR: begin
        add_a   = 32'(rel);
        add_b   = ~(32'(hdr_rd_data));
        add_cin = 1'b1;
      end
      default: ;
    endcase
  end

  assign add_sum  = add_a + add_b + 32'(add_cin);
  assign no_space = add_sum[14:0] > 15'(limit);
  assign rel_bad  = (add_sum < 32'(asa_pkg::HEADER_BYTES)) || (add_sum > 32'(top));

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= asa_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      asa_pkg::S_IDLE: begin
        if (req.valid) begin
          case (req.data.mode)
            asa_pkg::MODE_ALLOC: state_next = bad_align ? asa_pkg::S_DONE : asa_pkg::S_CUR;
            asa_pkg::MODE_FREE:  state_next = asa_pkg::S_REL;
            default:             state_next = asa_pkg::S_DONE;
          endcase
        end
      end
      asa_pkg::S_CUR:  state_next = asa_pkg::S_PAD;
      asa_pkg::S_PAD: begin
        if (pad >= 8'(asa_pkg::HEADER_BYTES)) begin
          state_next = asa_pkg::S_FIT;
        end
      end
      asa_pkg::S_FIT:  state_next = asa_pkg::S_CHK;
      asa_pkg::S_CHK:  state_next = no_space ? asa_pkg::S_DONE : asa_pkg::S_ADDR;
      asa_pkg::S_ADDR: state_next = asa_pkg::S_DONE;
      asa_pkg::S_REL:  state_next = rel_bad ? asa_pkg::S_DONE : asa_pkg::S_HDR;
      asa_pkg::S_HDR:  state_next = asa_pkg::S_DONE;
      asa_pkg::S_DONE: begin
        if (out_load) begin
          state_next = asa_pkg::S_IDLE;
        end
      end
      default: state_next = asa_pkg::S_IDLE;
    endcase
  end

  assign req.ready = (state == asa_pkg::S_IDLE);

  // datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      top  <= '0;
      peak <= '0;
    end else begin
      case (state)
        asa_pkg::S_IDLE: begin
          if (req.valid) begin
            cmd        <= req.data;
            res_addr   <= '0;
            res_status <= asa_pkg::STATUS_OK;
            if (req.data.mode == asa_pkg::MODE_ALLOC && bad_align) begin
              res_status <= asa_pkg::STATUS_BAD_ALIGN;
            end
            if (req.data.mode == asa_pkg::MODE_CLEAR) begin
              top  <= '0;
              peak <= '0;
            end
          end
        end
        asa_pkg::S_CUR: begin
          cur_addr <= add_sum;
          pad      <= (~add_sum[7:0] + 8'd1) & (cmd.alignment - 8'd1);
        end
        asa_pkg::S_PAD: begin
          if (pad < 8'(asa_pkg::HEADER_BYTES)) begin
            pad <= add_sum[7:0];
          end
        end
        asa_pkg::S_FIT: begin
          acc <= add_sum[14:0];
        end
        asa_pkg::S_CHK: begin
          if (no_space) begin
            res_status <= asa_pkg::STATUS_NO_SPACE;
          end else begin
            top <= add_sum[12:0];
          end
        end
        asa_pkg::S_ADDR: begin
          res_addr <= add_sum;
          if (top > peak) begin
            peak <= top;
          end
        end
        asa_pkg::S_REL: begin
          rel <= add_sum[12:0];
          if (rel_bad) begin
            res_status <= asa_pkg::STATUS_BAD_FREE;
          end
        end
        asa_pkg::S_HDR: begin
          top <= (13'(hdr_rd_data) > rel) ? 13'd0 : add_sum[12:0];
        end
        default: ;
      endcase
    end
  end

  // header RAM
  assign hdr_we     = (state == asa_pkg::S_CHK) && !no_space;
  assign hdr_wr_off = acc[12:0] - 13'(asa_pkg::HEADER_BYTES);
  assign hdr_rd_off = add_sum[12:0] - 13'(asa_pkg::HEADER_BYTES);
  assign wr_wide    = IW'(hdr_wr_off);
  assign rd_wide    = IW'(hdr_rd_off);

  asa_ram #(
    .WIDTH (asa_pkg::HDR_W),
    .DEPTH (MEM_BYTES)
  ) u_hdr_ram (
    .clk     (clk),
    .we      (hdr_we),
    .wr_addr (wr_wide[AW-1:0]),
    .wr_data (pad),
    .rd_addr (rd_wide[AW-1:0]),
    .rd_data (hdr_rd_data)
  );

  // output register
  assign out_load = (state == asa_pkg::S_DONE) && (!out_valid || rsp.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_word.result_address <= res_addr;
      out_word.status         <= res_status;
      out_word.used_bytes     <= top;
      out_word.peak_bytes     <= peak;
    end
  end

  assign rsp.valid = out_valid;
  assign rsp.data  = out_word;

  `ASA_ASSERT(a_top_in_region, clk, rst, 32'(top) <= 32'(MEM_BYTES), "offset beyond region")
  `ASA_ASSERT(a_peak_covers_top, clk, rst, (state != asa_pkg::S_ADDR) |-> (peak >= top), "peak below offset")
  `ASA_ASSERT(a_header_fits, clk, rst, hdr_we |-> (pad >= 8'(asa_pkg::HEADER_BYTES)), "padding leaves no header room")
  `ASA_ASSERT_NEXT(a_load_returns_idle, clk, rst, out_load, out_valid && (state == asa_pkg::S_IDLE), "result load did not finish the word")

endmodule
`default_nettype wire

// ----- tb/sv/aligned_stack_allocator_test.sv -----
`timescale 1ns / 1ps
// Self-checking bench for aligned_stack_allocator: directed and random words on the
// request channel, register writes between phases, responses checked against a shadow
// allocator. Depends on rtl/asa_pkg.sv, rtl/asa_ifs.sv and the allocator RTL.
module aligned_stack_allocator_test;

  localparam int MEM          = asa_pkg::MEM_BYTES_DEF;
  localparam int PLAN         = 0;
  localparam int CHECK        = 1;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int DRAIN_CYCLES = 20;

  logic clk;
  logic rst = 1'b1;

  asa_cfg_if cfg_if ();
  asa_req_if req_if ();
  asa_rsp_if rsp_if ();

  aligned_stack_allocator u_dut (
    .clk (clk),
    .rst (rst),
    .cfg (cfg_if),
    .req (req_if),
    .rsp (rsp_if)
  );

  // Shadow allocator, one copy steered by the stimulus plan and one by accepted words.
  logic [asa_pkg::ADDR_W-1:0] base_addr   [2] = '{default: '0};
  logic [asa_pkg::OFF_W-1:0]  region_size [2] = '{default: 13'd4096};
  logic [asa_pkg::OFF_W-1:0]  top_off     [2] = '{default: '0};
  logic [asa_pkg::OFF_W-1:0]  peak_off    [2] = '{default: '0};
  logic [asa_pkg::HDR_W-1:0]  pad_mem     [2][MEM];
  bit                         hdr_valid   [2][MEM];

  asa_pkg::req_t              pending_words[$];
  asa_pkg::rsp_t              expected_words[$];
  logic [asa_pkg::ADDR_W-1:0] live_blocks[$];

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned cycle_count    = 0;
  int unsigned fail_count     = 0;
  bit          req_took;

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  function automatic void apply_reg(input int v, input asa_pkg::cfg_index_t idx,
                                    input logic [asa_pkg::ADDR_W-1:0] value);
    case (idx)
      asa_pkg::CFG_BASE_ADDRESS: base_addr[v] = value;
      asa_pkg::CFG_TOTAL_SIZE:   region_size[v] = value[asa_pkg::OFF_W-1:0];
      default: ;
    endcase
  endfunction

  function automatic asa_pkg::rsp_t allocate_step(input int v, input asa_pkg::req_t w);
    asa_pkg::rsp_t o;
    logic [31:0]   cur;
    logic [31:0]   pad;
    logic [31:0]   rel;
    logic [31:0]   lim;
    int            slot;
    o.result_address = '0;
    o.status = asa_pkg::STATUS_OK;
    case (w.mode)
      asa_pkg::MODE_ALLOC: begin
        if (w.alignment == 0 || (w.alignment & (w.alignment - 8'd1)) != 0 ||
            w.alignment > asa_pkg::MAX_ALIGN) begin
          o.status = asa_pkg::STATUS_BAD_ALIGN;
        end else begin
          cur = base_addr[v] + 32'(top_off[v]);
          pad = (32'd0 - cur) & (32'(w.alignment) - 32'd1);
          while (pad < asa_pkg::HEADER_BYTES) pad += 32'(w.alignment);
          lim = (region_size[v] > MEM) ? 32'(MEM) : 32'(region_size[v]);
          if (32'(top_off[v]) + pad + 32'(w.request_size) > lim) begin
            o.status = asa_pkg::STATUS_NO_SPACE;
          end else begin
            slot = int'((32'(top_off[v]) + pad - asa_pkg::HEADER_BYTES) % MEM);
            pad_mem[v][slot] = pad[asa_pkg::HDR_W-1:0];
            hdr_valid[v][slot] = 1'b1;
            top_off[v] = asa_pkg::OFF_W'(32'(top_off[v]) + pad + 32'(w.request_size));
            if (top_off[v] > peak_off[v]) peak_off[v] = top_off[v];
            o.result_address = cur + pad;
          end
        end
      end
      asa_pkg::MODE_FREE: begin
        rel = w.free_address - base_addr[v];
        if (rel < asa_pkg::HEADER_BYTES || rel > 32'(top_off[v])) begin
          o.status = asa_pkg::STATUS_BAD_FREE;
        end else begin
          pad = 32'(pad_mem[v][int'((rel - asa_pkg::HEADER_BYTES) % MEM)]);
          top_off[v] = (pad > rel) ? '0 : asa_pkg::OFF_W'(rel - pad);
        end
      end
      asa_pkg::MODE_CLEAR: begin
        top_off[v] = '0;
        peak_off[v] = '0;
      end
      default: ;
    endcase
    o.used_bytes = top_off[v];
    o.peak_bytes = peak_off[v];
    return o;
  endfunction

  function automatic asa_pkg::req_t make_word(input asa_pkg::mode_t m, input int size,
                                              input int align,
                                              input logic [asa_pkg::ADDR_W-1:0] addr);
    asa_pkg::req_t w;
    w.mode = m;
    w.request_size = asa_pkg::OFF_W'(size);
    w.alignment = asa_pkg::ALIGN_W'(align);
    w.free_address = addr;
    return w;
  endfunction

  task automatic plan_word(input asa_pkg::req_t w);
    asa_pkg::rsp_t r;
    logic [31:0]   rel;
    // redirect a free that would read a header never written
    if (w.mode == asa_pkg::MODE_FREE) begin
      rel = w.free_address - base_addr[PLAN];
      if (rel >= asa_pkg::HEADER_BYTES && rel <= 32'(top_off[PLAN]) &&
          !hdr_valid[PLAN][int'(rel - asa_pkg::HEADER_BYTES)])
        w.free_address = base_addr[PLAN] + 32'(top_off[PLAN]) + 32'd1;
    end
    r = allocate_step(PLAN, w);
    pending_words.push_back(w);
    if (w.mode == asa_pkg::MODE_ALLOC && r.status == asa_pkg::STATUS_OK)
      live_blocks.push_back(r.result_address);
    while (live_blocks.size() != 0 &&
           (live_blocks[$] - base_addr[PLAN]) > 32'(top_off[PLAN]))
      void'(live_blocks.pop_back());
  endtask

  task automatic random_phase(input int count);
    asa_pkg::req_t w;
    int            pick;
    int            band;
    repeat (count) begin
      w.mode = asa_pkg::mode_t'($urandom_range(3));
      w.request_size = asa_pkg::OFF_W'($urandom_range(8191));
      w.alignment = asa_pkg::ALIGN_W'($urandom_range(255));
      w.free_address = $urandom;
      pick = $urandom_range(99);
      if (pick < 47 || (pick < 83 && live_blocks.size() == 0)) begin
        w.mode = asa_pkg::MODE_ALLOC;
        w.alignment = asa_pkg::ALIGN_W'(1 << $urandom_range(7));
        band = $urandom_range(99);
        if (band < 80) w.request_size = asa_pkg::OFF_W'($urandom_range(48));
        else if (band < 95) w.request_size = asa_pkg::OFF_W'($urandom_range(600));
      end else if (pick < 75) begin
        w.mode = asa_pkg::MODE_FREE;
        w.free_address = live_blocks[$];
      end else if (pick < 83) begin
        w.mode = asa_pkg::MODE_FREE;
        w.free_address = live_blocks[$urandom_range(live_blocks.size() - 1)];
      end else if (pick < 88) begin
        w.mode = asa_pkg::MODE_ALLOC;
      end else if (pick < 93) begin
        w.mode = asa_pkg::MODE_FREE;
        case ($urandom_range(2))
          0: w.free_address = base_addr[PLAN];
          1: w.free_address = base_addr[PLAN] + 32'(top_off[PLAN]) +
                              32'($urandom_range(1, 16));
          default: ;
        endcase
      end else if (pick < 96) begin
        w.mode = asa_pkg::MODE_CLEAR;
      end else begin
        w.mode = asa_pkg::MODE_NOP;
      end
      plan_word(w);
    end
  endtask

  task automatic write_reg(input asa_pkg::cfg_index_t idx,
                           input logic [asa_pkg::ADDR_W-1:0] value);
    @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.data <= '{index: idx, wdata: value};
    apply_reg(PLAN, idx, value);
    do @(posedge clk); while (!cfg_if.ready);
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic wait_idle();
    while (pending_words.size() != 0 || req_if.valid || expected_words.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_count++;
    end
  endtask

  // Driver: hold a word until it is taken, idle and stall at the phase's rates.
  always @(negedge clk) begin
    if (rst) begin
      req_if.valid <= 1'b0;
      rsp_if.ready <= 1'b0;
    end else begin
      rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
      if (!req_if.valid || req_took) begin
        if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          req_if.valid <= 1'b1;
          req_if.data <= pending_words.pop_front();
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: predict on each accepted word, check each accepted response.
  always @(posedge clk) begin
    asa_pkg::rsp_t want;
    if (rst) begin
      req_took <= 1'b0;
    end else begin
      req_took <= req_if.valid && req_if.ready;
      if (cfg_if.valid && cfg_if.ready)
        apply_reg(CHECK, cfg_if.data.index, cfg_if.data.wdata);
      if (req_if.valid && req_if.ready)
        expected_words.push_back(allocate_step(CHECK, req_if.data));
      if (rsp_if.valid && rsp_if.ready) begin
        if (expected_words.size() == 0) begin
          $error("response word with none expected: %p", rsp_if.data);
          fail_count++;
        end else begin
          want = expected_words.pop_front();
          check_field("result_address", want.result_address, rsp_if.data.result_address);
          check_field("status", 32'(want.status), 32'(rsp_if.data.status));
          check_field("used_bytes", 32'(want.used_bytes), 32'(rsp_if.data.used_bytes));
          check_field("peak_bytes", 32'(want.peak_bytes), 32'(rsp_if.data.peak_bytes));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    int          count;
    logic [31:0] base_sel;
    logic [31:0] size_sel;
    cfg_if.valid = 1'b0;
    cfg_if.data = '0;
    req_if.valid = 1'b0;
    req_if.data = '0;
    rsp_if.ready = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    plan_word(make_word(asa_pkg::MODE_ALLOC, 0, 1, 32'h0));
    plan_word(make_word(asa_pkg::MODE_ALLOC, 13, 128, 32'hFFFF_FFFF));
    plan_word(make_word(asa_pkg::MODE_ALLOC, 4096, 1, 32'h0));
    plan_word(make_word(asa_pkg::MODE_ALLOC, 8191, 64, 32'h0));
    plan_word(make_word(asa_pkg::MODE_ALLOC, 1, 0, 32'h0));
    plan_word(make_word(asa_pkg::MODE_ALLOC, 1, 3, 32'h0));
    plan_word(make_word(asa_pkg::MODE_ALLOC, 1, 129, 32'h0));
    plan_word(make_word(asa_pkg::MODE_ALLOC, 1, 255, 32'h0));
    plan_word(make_word(asa_pkg::MODE_ALLOC, 1, 128, 32'h0));
    plan_word(make_word(asa_pkg::MODE_FREE, 0, 1, 32'h0));
    plan_word(make_word(asa_pkg::MODE_FREE, 8191, 255, 32'hFFFF_FFFF));
    plan_word(make_word(asa_pkg::MODE_FREE, 0, 1, live_blocks[$]));
    plan_word(make_word(asa_pkg::MODE_FREE, 0, 1, live_blocks[$]));
    plan_word(make_word(asa_pkg::MODE_NOP, 8191, 255, 32'hFFFF_FFFF));
    plan_word(make_word(asa_pkg::MODE_CLEAR, 8191, 255, 32'hFFFF_FFFF));
    plan_word(make_word(asa_pkg::MODE_ALLOC, 4095, 1, 32'h0));
    plan_word(make_word(asa_pkg::MODE_ALLOC, 0, 1, 32'h0));
    plan_word(make_word(asa_pkg::MODE_FREE, 0, 1, live_blocks[$]));
    plan_word(make_word(asa_pkg::MODE_FREE, 0, 1, 32'h1));
    plan_word(make_word(asa_pkg::MODE_ALLOC, 4, 2, 32'h0));
    plan_word(make_word(asa_pkg::MODE_ALLOC, 0, 16, 32'h0));
    plan_word(make_word(asa_pkg::MODE_ALLOC, 7, 8, 32'h0));
    plan_word(make_word(asa_pkg::MODE_FREE, 0, 1, live_blocks[0]));
    plan_word(make_word(asa_pkg::MODE_CLEAR, 0, 1, 32'h0));
    random_phase(100);

    for (int p = 1; p < 8; p++) begin
      wait_idle();
      count = 260;
      case (p)
        1: begin
          base_sel = 32'hFFFF_FFFF;
          size_sel = 4096;
        end
        2: begin
          base_sel = $urandom;
          size_sel = 8191;
        end
        3: begin
          base_sel = 32'h0000_0003;
          size_sel = 300;
          count = 240;
        end
        4: begin
          base_sel = $urandom;
          size_sel = 0;
          count = 60;
        end
        5: begin
          base_sel = 32'hFFFF_F7FD;
          size_sel = 4095;
        end
        6: begin
          base_sel = $urandom;
          size_sel = $urandom_range(1, 4096);
        end
        default: begin
          base_sel = 32'h0;
          size_sel = 4096;
        end
      endcase
      write_reg(asa_pkg::CFG_BASE_ADDRESS, base_sel);
      write_reg(asa_pkg::CFG_TOTAL_SIZE, size_sel);
      live_blocks.delete();
      case (p % 4)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct = 85;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct = 85;
        end
        default: begin
          send_idle_pct = 23;
          recv_stall_pct = 23;
        end
      endcase
      random_phase(count);
    end

    wait_idle();
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
